>>> rtl/core/fcl_pkg.sv
// Package with shared constants and types for the fault code list with rotation.
package fcl_pkg;

  // Default depth of the fault list.
  localparam int LIST_DEPTH_DEF = 8;

  // Widths of the fixed payload fields.
  localparam int CODE_W  = 8;
  localparam int COUNT_W = 4;
  localparam int DWELL_W = 8;
  localparam int FUNC_W  = 2;

  // Dwell setting after reset.
  localparam logic [DWELL_W-1:0] DWELL_RESET = 8'd6;

  // Operation carried with each input beat.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_RAISE     = 2'd0,
    FUNC_CLEAR     = 2'd1,
    FUNC_CLEAR_ALL = 2'd2,
    FUNC_TICK      = 2'd3
  } func_t;

endpackage

>>> rtl/core/fault_code_list_with_rotation.sv
// Fault code list with raise, clear, clear-all and round-robin display rotation.
// Clear-all, zero codes and counting or empty-list ticks go from decode to the result; a
// rotating tick first reads the new code from the memory, and a raise or clear scans the
// list; a raise on a full list or a clear that closes a gap then shifts entries down.
// A new beat is taken only once the previous item has loaded its result register.
// Reset (synchronous, active low) empties the list, zeroes the display, loads a dwell of 6.
module fault_code_list_with_rotation
  import fcl_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] code
  input  logic [1:0]  in_tuser,   // [1:0] func
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] shown_code, [11:8] active_count, [15:12] zero
  // Configuration channel: dwell_ticks.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  // The sequencer walks the list one entry a cycle through a single read port and a
  // single write port. Reads are registered, so a scan or a shift runs as a short
  // pipeline: the address issued in one cycle is compared or copied in the next.
  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for an input beat
    ST_DISP,   // decode the latched operation
    ST_SCAN,   // search the list for the latched code
    ST_SHIFT,  // move entries down by one to close a gap or drop the oldest
    ST_TAIL,   // put a raised code in the last slot after a full-list shift
    ST_TREAD,  // take the newly displayed code from the memory
    ST_DONE    // load the result register
  } state_t;

  state_t              state_r;
  func_t               func_r;
  logic [CODE_W-1:0]   code_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DWELL_W-1:0]  dwell_r;
  logic [DWELL_W-1:0]  dwell_ticks_r;
  logic [IDX_W-1:0]    show_r;
  logic [CODE_W-1:0]   disp_r;
  logic [CNT_W-1:0]    issue_idx_r;  // next list entry to read
  logic [CNT_W-1:0]    chk_idx_r;    // entry whose data sits in rd_data_r
  logic                chk_v_r;
  logic                out_valid_r;
  logic [15:0]         out_data_r;

  // List storage.
  logic [CODE_W-1:0]   mem_r [LIST_DEPTH];
  logic [CODE_W-1:0]   rd_data_r;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [CODE_W-1:0]   wr_data;

  logic                hit;
  logic                exhausted;
  logic                full;
  logic                out_free;
  logic [CNT_W-1:0]    cnt_m1;
  logic [CNT_W-1:0]    chk_prev;
  logic [CNT_W-1:0]    show_ext;
  logic [IDX_W-1:0]    show_nxt;
  logic [CNT_W+3:0]    cnt_ext;

  assign hit       = chk_v_r && (rd_data_r == code_r);
  assign exhausted = issue_idx_r >= cnt_r;
  assign full      = cnt_r == CNT_W'(LIST_DEPTH);
  assign cnt_m1    = cnt_r - CNT_W'(1);
  assign chk_prev  = chk_idx_r - CNT_W'(1);
  assign show_ext  = CNT_W'(show_r);
  // Round-robin step: wrap to the first entry once the index reaches the last held one,
  // which also covers an index left past the end by earlier clears.
  assign show_nxt  = (show_ext >= cnt_m1) ? '0 : show_r + IDX_W'(1);
  assign cnt_ext   = {4'b0000, cnt_r};
  assign out_free  = !out_valid_r || out_tready;

  // The input side is open only between items; a waiting result does not block it.
  assign in_tready  = (state_r == ST_IDLE);
  // Only change the dwell setting while the block is idle: always taken, unchecked.
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Memory port control.
  always_comb begin
    rd_addr = issue_idx_r[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = cnt_r[IDX_W-1:0];
    wr_data = code_r;
    unique case (state_r)
      ST_DISP: begin
        rd_addr = show_nxt;
      end
      ST_SCAN: begin
        // Append a new code when the list still has room.
        wr_en = !hit && exhausted && (func_r == FUNC_RAISE) && !full;
      end
      ST_SHIFT: begin
        wr_en   = chk_v_r;
        wr_addr = chk_prev[IDX_W-1:0];
        wr_data = rd_data_r;
      end
      ST_TAIL: begin
        wr_en   = 1'b1;
        wr_addr = cnt_m1[IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  // Sequencer and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      dwell_r       <= '0;
      dwell_ticks_r <= DWELL_RESET;
      show_r        <= '0;
      disp_r        <= '0;
      chk_v_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dwell_ticks_r <= cfg_data;
      end
      // A new result is loaded when the register is free; otherwise an accepted
      // result empties it.
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            func_r  <= func_t'(in_tuser);
            code_r  <= in_tdata;
            state_r <= ST_DISP;
          end
        end
        ST_DISP: begin
          issue_idx_r <= '0;
          chk_v_r     <= 1'b0;
          unique case (func_r)
            FUNC_RAISE, FUNC_CLEAR: begin
              // Code zero means no error and is never held.
              state_r <= (code_r == '0) ? ST_DONE : ST_SCAN;
            end
            FUNC_CLEAR_ALL: begin
              cnt_r   <= '0;
              state_r <= ST_DONE;
            end
            FUNC_TICK: begin
              if (dwell_r >= dwell_ticks_r) begin
                dwell_r <= '0;
                if (cnt_r == '0) begin
                  disp_r  <= '0;
                  show_r  <= '0;
                  state_r <= ST_DONE;
                end else begin
                  show_r  <= show_nxt;
                  state_r <= ST_TREAD;
                end
              end else begin
                dwell_r <= dwell_r + DWELL_W'(1);
                state_r <= ST_DONE;
              end
            end
            default: begin
              state_r <= ST_DONE;
            end
          endcase
        end
        ST_SCAN: begin
          if (hit) begin
            if (func_r == FUNC_CLEAR) begin
              issue_idx_r <= chk_idx_r + CNT_W'(1);
              chk_v_r     <= 1'b0;
              state_r     <= ST_SHIFT;
            end else begin
              state_r <= ST_DONE;
            end
          end else if (exhausted) begin
            chk_v_r <= 1'b0;
            if (func_r == FUNC_RAISE) begin
              if (!full) begin
                cnt_r   <= cnt_r + CNT_W'(1);
                state_r <= ST_DONE;
              end else begin
                // Drop the oldest entry by shifting everything down from entry one.
                issue_idx_r <= CNT_W'(1);
                state_r     <= ST_SHIFT;
              end
            end else begin
              state_r <= ST_DONE;
            end
          end else begin
            chk_v_r     <= 1'b1;
            chk_idx_r   <= issue_idx_r;
            issue_idx_r <= issue_idx_r + CNT_W'(1);
          end
        end
        ST_SHIFT: begin
          if (exhausted) begin
            chk_v_r <= 1'b0;
            if (func_r == FUNC_RAISE) begin
              state_r <= ST_TAIL;
            end else begin
              cnt_r   <= cnt_m1;
              state_r <= ST_DONE;
            end
          end else begin
            chk_v_r     <= 1'b1;
            chk_idx_r   <= issue_idx_r;
            issue_idx_r <= issue_idx_r + CNT_W'(1);
          end
        end
        ST_TAIL: begin
          state_r <= ST_DONE;
        end
        ST_TREAD: begin
          disp_r  <= rd_data_r;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_data_r <= {4'b0000, cnt_ext[3:0], disp_r};
            state_r    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // The count never passes the list depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(LIST_DEPTH))
    else $error("fault count exceeds list depth");

  // One item moves the count by at most one, except clear-all which empties the list.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + CNT_W'(1)) ||
    (cnt_r == $past(cnt_r) - CNT_W'(1)) || (cnt_r == '0))
    else $error("fault count jumped");

  // An accepted input beat always starts decoding in the next cycle.
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_DISP))
    else $error("accepted beat was not decoded");

  // Shifting only happens on a non-empty list.
  a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> (cnt_r != '0))
    else $error("shift on an empty list");

endmodule
